// File: rtl/afc_pkg.sv
// Shared types and constants for the box-versus-frustum culling unit.
package afc_pkg;

  // Field widths
  localparam int COORD_W        = 16;
  localparam int PLANE_W        = 64;
  localparam int PROD_W         = 2 * COORD_W;
  // Three products of at most 2^30 plus the shifted offset stay below 2^32.
  localparam int DIST_W         = PROD_W + 2;
  localparam int OFF_SHIFT      = 14;
  localparam int NUM_AXES       = 3;
  localparam int NUM_PLANE_REGS = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int IN_TDATA_W     = 6 * COORD_W;
  localparam int RES_W          = 2;
  localparam int OUT_TDATA_W    = 8;

  // Result codes
  typedef enum logic [RES_W-1:0] {
    CONT_DISJOINT   = 2'd0,
    CONT_INTERSECTS = 2'd1,
    CONT_CONTAINED  = 2'd2
  } containment_e;

  // One box, min_x in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] max_z;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_x;
  } box_t;

  // One plane register, nx in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] offset;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } plane_t;

  // Per-plane verdict
  typedef struct packed {
    logic outside;
    logic straddle;
  } flags_t;

  // Load enables for the lane stages
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

// File: rtl/afc_plane_regs.sv
// Plane register file written through the configuration channel.
module afc_plane_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [afc_pkg::PLANE_W-1:0]       cfg_data_i,
  output afc_pkg::plane_t                   planes_o [afc_pkg::NUM_PLANE_REGS]
);
  import afc_pkg::*;

  plane_t planes_q [NUM_PLANE_REGS];

  // Store a write to a known index, drop anything beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
        planes_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
        if (cfg_index_i == CFG_IDX_W'(i)) begin
          planes_q[i] <= plane_t'(cfg_data_i);
        end
      end
    end
  end

  assign planes_o = planes_q;

endmodule

// File: rtl/afc_plane_lane.sv
// One plane lane: corner selection and products, then distance sums and compare.
module afc_plane_lane (
  input  logic                clk_i,
  input  afc_pkg::plane_t     plane_i,
  input  afc_pkg::box_t       box_i,
  input  afc_pkg::stage_en_t  en_i,
  output afc_pkg::flags_t     flags_o
);
  import afc_pkg::*;

  logic signed [COORD_W-1:0] nrm   [NUM_AXES];
  logic signed [COORD_W-1:0] lo    [NUM_AXES];
  logic signed [COORD_W-1:0] hi    [NUM_AXES];
  logic signed [PROD_W-1:0]  prod_n_d [NUM_AXES];
  logic signed [PROD_W-1:0]  prod_p_d [NUM_AXES];
  logic signed [PROD_W-1:0]  prod_n_q [NUM_AXES];
  logic signed [PROD_W-1:0]  prod_p_q [NUM_AXES];
  logic signed [DIST_W-1:0]  off;
  logic signed [DIST_W-1:0]  dist_n;
  logic signed [DIST_W-1:0]  dist_p;
  flags_t                    flags_d;
  flags_t                    flags_q;

  assign nrm[0] = plane_i.nx;
  assign nrm[1] = plane_i.ny;
  assign nrm[2] = plane_i.nz;
  assign lo[0]  = box_i.min_x;
  assign lo[1]  = box_i.min_y;
  assign lo[2]  = box_i.min_z;
  assign hi[0]  = box_i.max_x;
  assign hi[1]  = box_i.max_y;
  assign hi[2]  = box_i.max_z;

  // Pick the corners by normal sign (zero counts as non-negative) and multiply
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (nrm[a][COORD_W-1]) begin
        prod_p_d[a] = nrm[a] * lo[a];
        prod_n_d[a] = nrm[a] * hi[a];
      end else begin
        prod_p_d[a] = nrm[a] * hi[a];
        prod_n_d[a] = nrm[a] * lo[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_n_q <= prod_n_d;
      prod_p_q <= prod_p_d;
    end
  end

  // Sum the products with the offset scaled to the product's fraction
  always_comb begin
    off    = DIST_W'(plane_i.offset) <<< OFF_SHIFT;
    dist_n = DIST_W'(prod_n_q[0]) + DIST_W'(prod_n_q[1]) + DIST_W'(prod_n_q[2]) + off;
    dist_p = DIST_W'(prod_p_q[0]) + DIST_W'(prod_p_q[1]) + DIST_W'(prod_p_q[2]) + off;
    flags_d.outside  = (dist_n > 0);
    flags_d.straddle = !flags_d.outside && !dist_p[DIST_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

// File: rtl/aabb_frustum_cull_unit.sv
// Top level of the box-versus-frustum culling unit: handshake, lanes and verdict.
//
// Classifies one axis-aligned box per clock against NUM_PLANES planes and returns
// disjoint, intersects or fully contained. A new box is taken every cycle unless
// a stalled output has filled every stage. Each box passes through the
// three-stage pipeline (corner products, distance sums and compare, reduction
// over planes) before its result is presented. Every plane has its own lane
// with six 16x16 multipliers. Each stage holds its request until the next one
// is free, so an output stall fills bubbles before it stops the input. Planes
// beyond the six registers behave as all-zero planes and always count as
// intersecting. Write the plane registers only while idle.
module aabb_frustum_cull_unit #(
  parameter int NUM_PLANES = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [afc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [afc_pkg::PLANE_W-1:0]          cfg_data_i,
  // box stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: min_x, min_y, min_z, max_x, max_y, max_z (16 bits each, lowest first)
  input  logic [afc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: containment [1:0], zero fill [7:2]
  output logic [afc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import afc_pkg::*;

  plane_t       regs_w  [NUM_PLANE_REGS];
  plane_t       plane_w [NUM_PLANES];
  flags_t       flags_w [NUM_PLANES];
  box_t         box_w;
  stage_en_t    en_w;
  logic         v1_q, v2_q, v3_q;
  logic         rdy1, rdy2, rdy3;
  logic         outside_any;
  logic         straddle_any;
  containment_e result_d;
  containment_e result_q;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  afc_plane_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .planes_o    (regs_w)
  );

  // Each stage advances when it is empty or its successor advances
  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign en_w.s1       = rdy1;
  assign en_w.s2       = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign box_w = box_t'(s_axis_tdata);

  // One lane per plane; planes past the register file stay all zero
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    if (p < NUM_PLANE_REGS) begin : g_reg
      assign plane_w[p] = regs_w[p];
    end else begin : g_zero
      assign plane_w[p] = '0;
    end

    afc_plane_lane u_lane (
      .clk_i   (clk_i),
      .plane_i (plane_w[p]),
      .box_i   (box_w),
      .en_i    (en_w),
      .flags_o (flags_w[p])
    );
  end

  // Combine the plane verdicts: any outside wins, then any straddle
  always_comb begin
    outside_any  = 1'b0;
    straddle_any = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      outside_any  = outside_any  | flags_w[p].outside;
      straddle_any = straddle_any | flags_w[p].straddle;
    end
    priority if (outside_any) begin
      result_d = CONT_DISJOINT;
    end else if (straddle_any) begin
      result_d = CONT_INTERSECTS;
    end else begin
      result_d = CONT_CONTAINED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = OUT_TDATA_W'(result_q);

  // A taken box always occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted box did not enter the first stage");

  // Input is refused only when every stage is full
  a_ready_bubbles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v1_q && v2_q && v3_q)
    else $error("input stalled while a stage was empty");

  // A stalled output keeps the item behind it
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && v3_q && !m_axis_tready |=> v2_q)
    else $error("item lost in second stage during stall");

  // No result code outside the defined three
  a_code_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("undefined containment code");

endmodule

// File: sim/tb_aabb_frustum_cull_unit.sv
// Self-checking testbench for the box-versus-frustum culling unit.
module tb_aabb_frustum_cull_unit;
  import afc_pkg::*;

  localparam int NUM_PLANES  = 6;
  localparam int MAX_PLANES  = 8;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_TAIL  = 6;
  localparam int UNIT_NORMAL = 16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_0, REG_PLANE_1, REG_PLANE_2, REG_PLANE_3, REG_PLANE_4, REG_PLANE_5,
    REG_SPARE_6, REG_SPARE_7
  } plane_reg_e;

  typedef enum int {FR_CUBE, FR_SLANT, FR_RAW} frustum_kind_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [PLANE_W-1:0]     cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata: min_x, min_y, min_z, max_x, max_y, max_z (16 bits each, lowest first)
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // tdata: containment [1:0], zero fill [7:2]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  plane_t       plane_model [MAX_PLANES];
  plane_t       frustum_set [NUM_PLANE_REGS];
  containment_e verdicts_q [$];
  int           mismatches;
  int           quiet_cycles;
  bit           stalls_on;

  aabb_frustum_cull_unit #(
    .NUM_PLANES(NUM_PLANES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Classify a box against the modelled planes with exact products
  function automatic containment_e classify_box(box_t b);
    longint lo [3];
    longint hi [3];
    longint n [3];
    longint far_d;
    longint near_d;
    plane_t p;
    logic   outside;
    logic   straddle;
    lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
    hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
    outside  = 1'b0;
    straddle = 1'b0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      p = plane_model[i];
      n[0] = p.nx; n[1] = p.ny; n[2] = p.nz;
      far_d  = longint'(p.offset) * UNIT_NORMAL;
      near_d = far_d;
      // a zero component counts as non-negative: upper coordinate is the far one
      for (int a = 0; a < NUM_AXES; a++) begin
        if (n[a] >= 0) begin
          far_d  += n[a] * hi[a];
          near_d += n[a] * lo[a];
        end else begin
          far_d  += n[a] * lo[a];
          near_d += n[a] * hi[a];
        end
      end
      if (near_d > 0) begin
        outside = 1'b1;
      end else if (far_d >= 0) begin
        straddle = 1'b1;
      end
    end
    if (outside) return CONT_DISJOINT;
    if (straddle) return CONT_INTERSECTS;
    return CONT_CONTAINED;
  endfunction

  function automatic box_t mk_box(input int x0, y0, z0, x1, y1, z1);
    box_t b;
    b.min_x = 16'(x0); b.min_y = 16'(y0); b.min_z = 16'(z0);
    b.max_x = 16'(x1); b.max_y = 16'(y1); b.max_z = 16'(z1);
    return b;
  endfunction

  function automatic plane_t mk_plane(input int nx, ny, nz, off);
    plane_t p;
    p.nx = 16'(nx); p.ny = 16'(ny); p.nz = 16'(nz); p.offset = 16'(off);
    return p;
  endfunction

  // Random box around the origin; optionally swap some axes to invert it
  function automatic box_t near_box(input int span, half_max, bit invert);
    int c;
    int h;
    int t;
    int lo [3];
    int hi [3];
    for (int a = 0; a < NUM_AXES; a++) begin
      c = int'($urandom_range(2 * span)) - span;
      h = int'($urandom_range(half_max));
      lo[a] = c - h;
      hi[a] = c + h;
      if (invert && $urandom_range(1)) begin
        t = lo[a]; lo[a] = hi[a]; hi[a] = t;
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  function automatic box_t pick_box(frustum_kind_e kind);
    int r;
    r = $urandom_range(99);
    if (kind == FR_RAW) begin
      if (r < 70) return box_t'({$urandom, $urandom, $urandom});
      return near_box(2000, 1500, 1'b0);
    end
    if (r < 80) return near_box(8000, 4000, 1'b0);
    if (r < 90) return near_box(8000, 4000, 1'b1);
    return box_t'({$urandom, $urandom, $urandom});
  endfunction

  // Build an axis-aligned box of planes around a centre, with a half-length per axis
  task automatic cube_set(input int cx, cy, cz, lx, ly, lz);
    frustum_set[0] = mk_plane( UNIT_NORMAL, 0, 0, -(cx + lx));
    frustum_set[1] = mk_plane(-UNIT_NORMAL, 0, 0, cx - lx);
    frustum_set[2] = mk_plane(0,  UNIT_NORMAL, 0, -(cy + ly));
    frustum_set[3] = mk_plane(0, -UNIT_NORMAL, 0, cy - ly);
    frustum_set[4] = mk_plane(0, 0,  UNIT_NORMAL, -(cz + lz));
    frustum_set[5] = mk_plane(0, 0, -UNIT_NORMAL, cz - lz);
  endtask

  // Score, predict and watch for a stuck handshake on every rising edge
  always @(posedge clk_i) begin : score_proc
    containment_e want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (verdicts_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %0d", $time,
                 m_axis_tdata[RES_W-1:0]);
      end else begin
        want = verdicts_q.pop_front();
        if (m_axis_tdata[RES_W-1:0] !== want) begin
          mismatches++;
          $display("%0t: containment mismatch, expected %0d, got %0d", $time, want,
                   m_axis_tdata[RES_W-1:0]);
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      verdicts_q.push_back(classify_box(s_axis_tdata));
    end
    if (cfg_valid_i && cfg_ready_o && cfg_index_i < NUM_PLANE_REGS) begin
      plane_model[cfg_index_i] = cfg_data_i;
    end
    if (!rst_ni || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("aabb_frustum_cull_unit verification failed");
      $finish;
    end
  end

  // Stall the result stream at random unless stalls are switched off
  always @(negedge clk_i) begin
    m_axis_tready <= stalls_on ? ($urandom_range(99) >= 13) : 1'b1;
  end

  // Send one box request, with a random gap in front; leave valid high after
  task automatic send_box(input box_t b);
    while (stalls_on && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drop the box stream and hold until every verdict has come back
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (verdicts_q.size() != 0);
  endtask

  task automatic set_reg(input plane_reg_e idx, input logic [PLANE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Write the whole plane set, plus a spare index now and then
  task automatic load_frustum(input bit spare);
    for (int i = 0; i < NUM_PLANE_REGS; i++) begin
      set_reg(plane_reg_e'(i), frustum_set[i]);
    end
    if (spare) begin
      set_reg($urandom_range(1) ? REG_SPARE_7 : REG_SPARE_6, {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Planes left at reset are all zero: every box intersects
  task automatic test_reset_planes();
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
    send_box(mk_box(5, -7, 9, 5, -7, 9));
  endtask

  // Axis-aligned cube: inside, straddling, outside, touching faces, inverted
  task automatic test_axis_cube();
    quiesce();
    cube_set(0, 0, 0, 100, 100, 100);
    load_frustum(1'b0);
    send_box(mk_box(-10, -10, -10, 10, 10, 10));
    send_box(mk_box(-10, -10, -10, 150, 10, 10));
    send_box(mk_box(200, -10, -10, 300, 10, 10));
    send_box(mk_box(-10, -10, -10, 100, 10, 10));
    send_box(mk_box(100, -10, -10, 120, 10, 10));
    send_box(mk_box(-10, -10, 101, 10, 10, 140));
    send_box(mk_box(150, -10, -10, 50, 10, 10));
    send_box(mk_box(-99, -99, -99, 99, 99, 99));
  endtask

  // Writes to indexes past the plane registers must change nothing
  task automatic test_spare_index();
    quiesce();
    set_reg(REG_SPARE_6, {$urandom, $urandom});
    set_reg(REG_SPARE_7, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    send_box(mk_box(-20, -20, -20, 20, 20, 20));
    send_box(mk_box(-300, -20, -20, -200, 20, 20));
  endtask

  // Extreme normals and offsets against extreme boxes
  task automatic test_extreme_planes();
    quiesce();
    frustum_set[0] = mk_plane(-32768, 32767, -32768, 32767);
    frustum_set[1] = mk_plane(32767, -32768, 32767, -32768);
    for (int i = 2; i < NUM_PLANE_REGS; i++) begin
      frustum_set[i] = mk_plane(0, 0, 0, -32768);
    end
    load_frustum(1'b0);
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
    send_box(mk_box(-32768, 32767, -32768, 32767, -32768, 32767));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
  endtask

  // Random phases: axis-aligned boxes, slanted sets and raw register values
  task automatic test_random_frusta();
    frustum_kind_e kind;
    for (int ph = 0; ph < 13; ph++) begin
      quiesce();
      kind = frustum_kind_e'(ph % 3);
      case (kind)
        FR_CUBE: begin
          cube_set(int'($urandom_range(8000)) - 4000, int'($urandom_range(8000)) - 4000,
                   int'($urandom_range(8000)) - 4000, 200 + $urandom_range(5800),
                   200 + $urandom_range(5800), 200 + $urandom_range(5800));
        end
        FR_SLANT: begin
          for (int i = 0; i < NUM_PLANE_REGS; i++) begin
            frustum_set[i] = mk_plane(int'($urandom_range(32768)) - UNIT_NORMAL,
                                      int'($urandom_range(32768)) - UNIT_NORMAL,
                                      int'($urandom_range(32768)) - UNIT_NORMAL,
                                      -int'($urandom_range(4000)));
          end
        end
        default: begin
          for (int i = 0; i < NUM_PLANE_REGS; i++) begin
            frustum_set[i] = plane_t'({$urandom, $urandom});
          end
        end
      endcase
      load_frustum($urandom_range(99) < 30);
      // one phase runs with no gaps on either side
      stalls_on = (ph != 4);
      for (int k = 0; k < 87; k++) begin
        if (ph == 7 && k == 40) begin
          quiesce();
        end
        send_box(pick_box(kind));
      end
    end
    stalls_on = 1'b1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_PLANE_0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    stalls_on     = 1'b1;
    for (int i = 0; i < MAX_PLANES; i++) begin
      plane_model[i] = '0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_planes();
    test_axis_cube();
    test_spare_index();
    test_extreme_planes();
    test_random_frusta();
    quiesce();
    repeat (DRAIN_TAIL) @(negedge clk_i);
    if (mismatches == 0 && verdicts_q.size() == 0) begin
      $display("aabb_frustum_cull_unit verification clean");
    end else begin
      $display("aabb_frustum_cull_unit verification failed");
    end
    $finish;
  end

endmodule

// File: aabb_frustum_cull_unit.f
rtl/afc_pkg.sv
rtl/afc_plane_regs.sv
rtl/afc_plane_lane.sv
rtl/aabb_frustum_cull_unit.sv
sim/tb_aabb_frustum_cull_unit.sv
